/* src/dstsr_pkg.sv */
// Shared types, field widths and codes for the dense slot table.
`timescale 1ns / 1ps

package dstsr_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_TABLE_ENTRIES = 1024;
  localparam int DEF_VALUE_WIDTH   = 32;

  // Fixed field widths
  localparam int MODE_W     = 2;
  localparam int ENTITY_W   = 10;
  localparam int ENTITIES   = 1 << ENTITY_W;
  localparam int VALUE_IO_W = 32;
  localparam int STATUS_W   = 2;
  localparam int SLOT_IO_W  = 10;
  localparam int TOTAL_W    = 11;

  // Stream word widths, padded to whole bytes
  localparam int IN_BITS    = ENTITY_W + VALUE_IO_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = VALUE_IO_W + SLOT_IO_W + TOTAL_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [ENTITY_W-1:0] entity_t;

  // Request modes
  localparam mode_t MODE_INSERT  = 2'd0;
  localparam mode_t MODE_REMOVE  = 2'd1;
  localparam mode_t MODE_GET     = 2'd2;
  localparam mode_t MODE_DESTROY = 2'd3;

  // Result status codes
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_DUP    = 2'd1;
  localparam status_t ST_ABSENT = 2'd2;
  localparam status_t ST_FULL   = 2'd3;

endpackage

/* src/dstsr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dstsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/dense_slot_table_swap_remove_top.sv */
// Sparse-set component table with swap-remove: top level.
//
// Usage:
//   Requests arrive on the s_axis channel, one word each. tuser carries the
//   mode (insert, remove, get, destroy if present); tdata carries the entity
//   id and, for an insert, the component value. Every request yields exactly
//   one result word on m_axis: status in tuser, and in tdata the value read
//   by a get, the slot concerned and the entry count after the request.
//   After accept, every request passes through S_MAP and ends in S_DONE: an
//   insert goes straight on, a get of a present entity goes by way of S_GET,
//   a remove or destroy of a present entity by way of S_RM1 and S_RM2, and an
//   absent or duplicate entity goes straight on. Requests are handled one at a
//   time: the entity map, slot map and value RAM each have a registered read,
//   and a new request is taken only once the last result is loaded for output.
//   A finished result sits in the output register; the next request is
//   accepted while it waits. If the receiver stalls, the block finishes the
//   following request and then holds it until the output register frees up.
//   After reset the entity map (which carries the presence bits) is cleared
//   one entry per cycle: s_axis_tready stays low until every entry is clear.
`timescale 1ns / 1ps

module dense_slot_table_swap_remove_top
  import dstsr_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int VALUE_WIDTH   = DEF_VALUE_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [9:0] entity_id, [41:10] component_value, upper bits zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] mode
  input  logic [MODE_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [31:0] component_data, [41:32] slot_index, [52:42] entry_total, upper zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output logic [STATUS_W-1:0]   m_axis_tuser
);

  localparam int SW = $clog2(TABLE_ENTRIES);       // slot address width
  localparam int CW = $clog2(TABLE_ENTRIES + 1);   // entry count width
  localparam int EW = SW + 1;                      // map word: {present, slot}

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MAP   = 3'd2;
  localparam logic [2:0] S_GET   = 3'd3;
  localparam logic [2:0] S_RM1   = 3'd4;
  localparam logic [2:0] S_RM2   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]             state;
  logic [ENTITY_W-1:0]    clr_addr;
  logic [CW-1:0]          count;
  mode_t                  req_mode;
  entity_t                req_ent;
  logic [VALUE_WIDTH-1:0] req_val;
  logic [SW-1:0]          gone;
  status_t                res_status;
  logic [VALUE_IO_W-1:0]  res_data;
  logic [SW-1:0]          res_slot;

  // memory ports
  logic                   e2s_we;
  entity_t                e2s_waddr;
  logic [EW-1:0]          e2s_wdata;
  logic [EW-1:0]          e2s_rdata;
  logic                   s2e_we;
  logic [SW-1:0]          s2e_waddr;
  entity_t                s2e_wdata;
  entity_t                s2e_rdata;
  logic                   val_we;
  logic [SW-1:0]          val_waddr;
  logic [VALUE_WIDTH-1:0] val_wdata;
  logic [SW-1:0]          val_raddr;
  logic [VALUE_WIDTH-1:0] val_rdata;

  logic          map_present;
  logic [SW-1:0] map_slot;
  logic [SW-1:0] last_slot;
  logic [SW-1:0] tail_slot;
  logic          full;
  logic          ins_ok;
  logic          rm_ok;
  logic          in_fire;
  logic          out_load;

  assign map_present = e2s_rdata[SW];
  assign map_slot    = e2s_rdata[SW-1:0];
  assign last_slot   = SW'(count - 1'b1);
  assign tail_slot   = count[SW-1:0];
  assign full        = (count == CW'(TABLE_ENTRIES));
  assign ins_ok      = (req_mode == MODE_INSERT) && !map_present && !full;
  assign rm_ok       = ((req_mode == MODE_REMOVE) || (req_mode == MODE_DESTROY)) &&
                       map_present && (count != '0);

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  // entity -> {present, slot}; cleared by the pass after reset
  dstsr_ram #(.WIDTH(EW), .DEPTH(ENTITIES)) u_e2s (
    .clk   (clk),
    .we    (e2s_we),
    .waddr (e2s_waddr),
    .wdata (e2s_wdata),
    .raddr (s_axis_tdata[ENTITY_W-1:0]),
    .rdata (e2s_rdata)
  );

  // slot -> entity
  dstsr_ram #(.WIDTH(ENTITY_W), .DEPTH(TABLE_ENTRIES)) u_s2e (
    .clk   (clk),
    .we    (s2e_we),
    .waddr (s2e_waddr),
    .wdata (s2e_wdata),
    .raddr (last_slot),
    .rdata (s2e_rdata)
  );

  // packed component values
  dstsr_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(TABLE_ENTRIES)) u_val (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  // get reads through the map slot; remove reads the last occupied slot
  assign val_raddr = (req_mode == MODE_GET) ? map_slot : last_slot;

  // write ports
  always_comb begin
    e2s_we    = 1'b0;
    e2s_waddr = req_ent;
    e2s_wdata = '0;
    s2e_we    = 1'b0;
    s2e_waddr = tail_slot;
    s2e_wdata = req_ent;
    val_we    = 1'b0;
    val_waddr = tail_slot;
    val_wdata = req_val;
    case (state)
      S_CLEAR: begin
        e2s_we    = 1'b1;
        e2s_waddr = clr_addr;
      end
      S_MAP: begin
        // insert appends at the tail
        if (ins_ok) begin
          e2s_we    = 1'b1;
          e2s_wdata = {1'b1, tail_slot};
          s2e_we    = 1'b1;
          val_we    = 1'b1;
        end
      end
      S_RM1: begin
        // move the tail entry into the freed slot
        e2s_we    = 1'b1;
        e2s_waddr = s2e_rdata;
        e2s_wdata = {1'b1, gone};
        s2e_we    = 1'b1;
        s2e_waddr = gone;
        s2e_wdata = s2e_rdata;
        val_we    = 1'b1;
        val_waddr = gone;
        val_wdata = val_rdata;
      end
      S_RM2: begin
        // drop the mark last, so removing the tail entry leaves it absent
        e2s_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      count    <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ENTITY_W'(ENTITIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            state <= S_MAP;
          end
        end
        S_MAP: begin
          case (req_mode)
            MODE_INSERT: begin
              if (ins_ok) begin
                count <= count + 1'b1;
              end
              state <= S_DONE;
            end
            MODE_GET: begin
              state <= map_present ? S_GET : S_DONE;
            end
            MODE_REMOVE, MODE_DESTROY: begin
              state <= rm_ok ? S_RM1 : S_DONE;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_GET: begin
          state <= S_DONE;
        end
        S_RM1: begin
          state <= S_RM2;
        end
        S_RM2: begin
          count <= count - 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request and result registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_mode <= s_axis_tuser;
      req_ent  <= s_axis_tdata[ENTITY_W-1:0];
      req_val  <= VALUE_WIDTH'(s_axis_tdata[ENTITY_W +: VALUE_IO_W]);
    end
    if (state == S_MAP) begin
      gone       <= map_slot;
      res_data   <= '0;
      res_slot   <= '0;
      res_status <= ST_OK;
      case (req_mode)
        MODE_INSERT: begin
          if (map_present) begin
            res_status <= ST_DUP;
            res_slot   <= map_slot;
          end else if (full) begin
            res_status <= ST_FULL;
          end else begin
            res_slot <= tail_slot;
          end
        end
        MODE_GET: begin
          if (map_present) begin
            res_slot <= map_slot;
          end else begin
            res_status <= ST_ABSENT;
          end
        end
        MODE_REMOVE, MODE_DESTROY: begin
          if (rm_ok) begin
            res_slot <= map_slot;
          end else begin
            res_status <= ST_ABSENT;
          end
        end
        default: begin
          res_status <= ST_ABSENT;
        end
      endcase
    end
    if (state == S_GET) begin
      res_data <= VALUE_IO_W'(val_rdata);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tuser <= res_status;
      m_axis_tdata <= OUT_DATA_W'({TOTAL_W'(count), SLOT_IO_W'(res_slot), res_data});
    end
  end

endmodule
